FILE: hdl/bfsa_pkg.sv
package bfsa_pkg;

  localparam int unsigned LEN_W     = 17;
  localparam int unsigned START_W   = 16;
  localparam int unsigned UNIT_W    = 13;
  localparam int unsigned OWN_W     = 7;
  localparam int unsigned FILL_W    = 8;
  localparam int unsigned SIZE_W    = LEN_W + 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STEP_W    = $clog2(LEN_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT  = 2'd1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [FILL_W-1:0] FREE_MARK  = 8'hFF;
  localparam logic [LEN_W-1:0]  MEM_LIMIT  = 17'd65536;
  localparam logic [UNIT_W-1:0] UNIT_RESET = 13'd16;
  localparam logic [UNIT_W-1:0] UNIT_MIN   = 13'd1;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_NO_FIT   = 2'd1;
  localparam status_t ST_NO_OWNER = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  typedef struct packed {
    logic [FILL_W-1:0] owner;
    logic [LEN_W-1:0]  start;
    logic [LEN_W-1:0]  len;
  } seg_entry_t;

  typedef struct packed {
    status_t            status;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic [FILL_W-1:0]  fill;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [LEN_W-1:0]  dividend;
    logic [UNIT_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic              done;
    logic [UNIT_W-1:0] rem;
  } rem_rsp_t;

endpackage

FILE: hdl/bfsa_rem.sv
module bfsa_rem (
  input  logic               clk,
  input  logic               rst_n,
  input  bfsa_pkg::rem_req_t req,
  output bfsa_pkg::rem_rsp_t rsp
);

  logic [bfsa_pkg::LEN_W-1:0]  dvd_r, dvd_nxt;
  logic [bfsa_pkg::UNIT_W-1:0] dvs_r, dvs_nxt;
  logic [bfsa_pkg::UNIT_W-1:0] rem_r, rem_nxt;
  logic [bfsa_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [bfsa_pkg::UNIT_W:0]   shifted;
  logic [bfsa_pkg::UNIT_W:0]   trial;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign shifted = {rem_r, dvd_r[bfsa_pkg::LEN_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      step_nxt = bfsa_pkg::STEP_W'(bfsa_pkg::LEN_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[bfsa_pkg::LEN_W-2:0], 1'b0};
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = trial[bfsa_pkg::UNIT_W-1:0];
      end else begin
        rem_nxt = shifted[bfsa_pkg::UNIT_W-1:0];
      end
      step_nxt = step_r - 1'b1;
      if (step_r == bfsa_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: hdl/bfsa_table.sv
module bfsa_table #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic [bfsa_pkg::LEN_W-1:0]   total,
  input  logic [IDX_W-1:0]             rd_addr,
  output bfsa_pkg::seg_entry_t         rd_data,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_addr,
  input  bfsa_pkg::seg_entry_t         wr_data
);

  bfsa_pkg::seg_entry_t mem [DEPTH];
  bfsa_pkg::seg_entry_t q_r;
  bfsa_pkg::seg_entry_t init_entry;
  logic                 init_r;
  logic                 rd_init_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_r <= mem[rd_addr];
  end

  // entry 0 reads as the whole memory free after reset or clear, until the first write lands there
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r    <= 1'b1;
      rd_init_r <= 1'b0;
    end else begin
      if (clear) begin
        init_r <= 1'b1;
      end else if (wr_en && (wr_addr == '0)) begin
        init_r <= 1'b0;
      end
      rd_init_r <= init_r && (rd_addr == '0);
    end
  end

  always_comb begin
    init_entry.owner = bfsa_pkg::FREE_MARK;
    init_entry.start = '0;
    init_entry.len   = total;
  end

  assign rd_data = rd_init_r ? init_entry : q_r;

endmodule

FILE: hdl/bfsa_seq.sv
module bfsa_seq #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned IDX_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clear,
  input  logic [bfsa_pkg::UNIT_W-1:0]    unit,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [bfsa_pkg::OWN_W-1:0]     in_owner_id,
  input  logic [bfsa_pkg::LEN_W-1:0]     in_request_bytes,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bfsa_pkg::result_t              out_res,
  output bfsa_pkg::rem_req_t             rem_req,
  input  bfsa_pkg::rem_rsp_t             rem_rsp,
  output logic [IDX_W-1:0]               rd_addr,
  input  bfsa_pkg::seg_entry_t           rd_data,
  output logic                           wr_en,
  output logic [IDX_W-1:0]               wr_addr,
  output bfsa_pkg::seg_entry_t           wr_data
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_DIV       = 10'b0000000010,
    S_SCAN      = 10'b0000000100,
    S_DECIDE    = 10'b0000001000,
    S_SHIFT     = 10'b0000010000,
    S_SPLIT_HI  = 10'b0000100000,
    S_SPLIT_LO  = 10'b0001000000,
    S_MERGE     = 10'b0010000000,
    S_MERGE_END = 10'b0100000000,
    S_DONE      = 10'b1000000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            kind_r, kind_nxt;
  logic [bfsa_pkg::OWN_W-1:0]      owner_r, owner_nxt;
  logic [bfsa_pkg::LEN_W-1:0]      req_r, req_nxt;
  logic [bfsa_pkg::SIZE_W-1:0]     size_r, size_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [CNT_W-1:0]                ra_r, ra_nxt;
  logic                            dv_r, dv_nxt;
  logic [IDX_W-1:0]                didx_r, didx_nxt;
  logic                            found_r, found_nxt;
  logic [IDX_W-1:0]                best_r, best_nxt;
  logic [bfsa_pkg::LEN_W-1:0]      best_len_r, best_len_nxt;
  logic [bfsa_pkg::LEN_W-1:0]      best_begin_r, best_begin_nxt;
  logic [IDX_W-1:0]                w_r, w_nxt;
  bfsa_pkg::seg_entry_t            acc_r, acc_nxt;
  bfsa_pkg::result_t               res_r, res_nxt;
  bfsa_pkg::result_t               out_r, out_nxt;
  logic                            out_valid_r, out_valid_nxt;

  logic                            accept;
  logic                            issue;
  logic [bfsa_pkg::LEN_W-1:0]      size_len;
  logic [bfsa_pkg::FILL_W-1:0]     owner_fill;
  bfsa_pkg::seg_entry_t            merge_in;
  logic                            fit;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign size_len   = size_r[bfsa_pkg::LEN_W-1:0];
  assign owner_fill = {1'b0, owner_r};
  assign rd_addr    = ra_r[IDX_W-1:0];

  always_comb begin
    rem_req.start    = accept && (in_kind == bfsa_pkg::KIND_ALLOC) && (in_request_bytes != '0);
    rem_req.dividend = in_request_bytes;
    rem_req.divisor  = unit;
  end

  always_comb begin
    case (state_r)
      S_SCAN, S_MERGE: issue = (ra_r < count_r);
      S_SHIFT:         issue = (ra_r > CNT_W'(best_r));
      default:         issue = 1'b0;
    endcase
  end

  // best-fit test for the entry coming out of the table
  assign fit = (rd_data.owner == bfsa_pkg::FREE_MARK) &&
               ({1'b0, rd_data.len} >= size_r) &&
               (!found_r || (rd_data.len < best_len_r));

  always_comb begin
    merge_in = rd_data;
    if (didx_r == best_r) begin
      merge_in.owner = bfsa_pkg::FREE_MARK;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    owner_nxt      = owner_r;
    req_nxt        = req_r;
    size_nxt       = size_r;
    count_nxt      = count_r;
    ra_nxt         = ra_r;
    dv_nxt         = issue;
    didx_nxt       = ra_r[IDX_W-1:0];
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_len_nxt   = best_len_r;
    best_begin_nxt = best_begin_r;
    w_nxt          = w_r;
    acc_nxt        = acc_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = acc_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt  = in_kind;
          owner_nxt = in_owner_id;
          req_nxt   = in_request_bytes;
          ra_nxt    = '0;
          found_nxt = 1'b0;
          res_nxt   = '0;
          if (in_kind == bfsa_pkg::KIND_FREE) begin
            state_nxt = S_SCAN;
          end else if (in_request_bytes == '0) begin
            res_nxt.status = bfsa_pkg::ST_NO_FIT;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (rem_rsp.done) begin
          // round up to the next multiple of the unit
          if (rem_rsp.rem == '0) begin
            size_nxt = {1'b0, req_r};
          end else begin
            size_nxt = {1'b0, req_r} - bfsa_pkg::SIZE_W'(rem_rsp.rem) +
                       bfsa_pkg::SIZE_W'(unit);
          end
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          ra_nxt = ra_r + 1'b1;
        end
        if (dv_r) begin
          if (kind_r == bfsa_pkg::KIND_ALLOC) begin
            if (fit) begin
              found_nxt      = 1'b1;
              best_nxt       = didx_r;
              best_len_nxt   = rd_data.len;
              best_begin_nxt = rd_data.start;
            end
          end else if (!found_r && (rd_data.owner == owner_fill)) begin
            found_nxt      = 1'b1;
            best_nxt       = didx_r;
            best_len_nxt   = rd_data.len;
            best_begin_nxt = rd_data.start;
          end
        end
        if (!issue && !dv_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_nxt = '0;
        if (kind_r == bfsa_pkg::KIND_ALLOC) begin
          if (!found_r) begin
            res_nxt.status = bfsa_pkg::ST_NO_FIT;
            state_nxt      = S_DONE;
          end else if (({1'b0, best_len_r} > size_r) && (count_r == CNT_W'(DEPTH))) begin
            res_nxt.status = bfsa_pkg::ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            res_nxt.status = bfsa_pkg::ST_DONE;
            res_nxt.start  = best_begin_r[bfsa_pkg::START_W-1:0];
            res_nxt.len    = size_len;
            res_nxt.fill   = owner_fill;
            if ({1'b0, best_len_r} == size_r) begin
              wr_en         = 1'b1;
              wr_addr       = best_r;
              wr_data.owner = owner_fill;
              wr_data.start = best_begin_r;
              wr_data.len   = size_len;
              state_nxt     = S_DONE;
            end else begin
              ra_nxt    = count_r - 1'b1;
              state_nxt = S_SHIFT;
            end
          end
        end else begin
          if (!found_r) begin
            res_nxt.status = bfsa_pkg::ST_NO_OWNER;
            state_nxt      = S_DONE;
          end else begin
            res_nxt.status = bfsa_pkg::ST_DONE;
            res_nxt.start  = best_begin_r[bfsa_pkg::START_W-1:0];
            res_nxt.len    = best_len_r;
            res_nxt.fill   = bfsa_pkg::FREE_MARK;
            ra_nxt         = '0;
            w_nxt          = '0;
            state_nxt      = S_MERGE;
          end
        end
      end
      S_SHIFT: begin
        // move entries above the split one slot up, top first
        if (issue) begin
          ra_nxt = ra_r - 1'b1;
        end
        if (dv_r) begin
          wr_en   = 1'b1;
          wr_addr = didx_r + 1'b1;
          wr_data = rd_data;
        end
        if (!issue && !dv_r) begin
          state_nxt = S_SPLIT_HI;
        end
      end
      S_SPLIT_HI: begin
        wr_en         = 1'b1;
        wr_addr       = best_r + 1'b1;
        wr_data.owner = bfsa_pkg::FREE_MARK;
        wr_data.start = best_begin_r + size_len;
        wr_data.len   = best_len_r - size_len;
        state_nxt     = S_SPLIT_LO;
      end
      S_SPLIT_LO: begin
        wr_en         = 1'b1;
        wr_addr       = best_r;
        wr_data.owner = owner_fill;
        wr_data.start = best_begin_r;
        wr_data.len   = size_len;
        count_nxt     = count_r + 1'b1;
        state_nxt     = S_DONE;
      end
      S_MERGE: begin
        // compact the table, folding each free run into its first entry
        if (issue) begin
          ra_nxt = ra_r + 1'b1;
        end
        if (dv_r) begin
          if (didx_r == '0) begin
            acc_nxt = merge_in;
          end else if ((acc_r.owner == bfsa_pkg::FREE_MARK) &&
                       (merge_in.owner == bfsa_pkg::FREE_MARK)) begin
            acc_nxt.len = acc_r.len + merge_in.len;
          end else begin
            wr_en   = 1'b1;
            wr_addr = w_r;
            wr_data = acc_r;
            w_nxt   = w_r + 1'b1;
            acc_nxt = merge_in;
          end
        end
        if (!issue && !dv_r) begin
          state_nxt = S_MERGE_END;
        end
      end
      S_MERGE_END: begin
        wr_en     = 1'b1;
        wr_addr   = w_r;
        wr_data   = acc_r;
        count_nxt = CNT_W'(w_r) + 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (clear) begin
      count_nxt = CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    owner_r      <= owner_nxt;
    req_r        <= req_nxt;
    size_r       <= size_nxt;
    ra_r         <= ra_nxt;
    didx_r       <= didx_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    best_len_r   <= best_len_nxt;
    best_begin_r <= best_begin_nxt;
    w_r          <= w_nxt;
    acc_r        <= acc_nxt;
    res_r        <= res_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

FILE: hdl/best_fit_segment_allocator.sv
// Best-fit segment allocator over a memory of total_bytes bytes.
// Input channel (in_valid/in_ready): one item is an allocate (in_kind 0) of
// in_request_bytes for in_owner_id, or a free (in_kind 1) of the first
// segment owned by in_owner_id. Each item gives exactly one result item on
// out_valid/out_ready carrying status, start, length and fill owner.
// Configuration (cfg_we/cfg_index/cfg_data) must be written only while idle;
// the block does not enforce it. Index 0 sets total_bytes and empties the
// table, index 1 sets unit_bytes. An allocate rounds the size in the
// remainder unit, scans the table through its single read port and decides,
// then loads the output register; a split also moves the entries above the
// chosen one up by one slot. A free scans the table, then makes one
// compaction pass. A new item is taken in the cycle after the previous
// result is loaded.
// in_ready is high only while no item is in flight; a finished result waits
// in the output register and the next item is still taken, but its result
// is held until the receiver takes the previous one.
// Reset (synchronous, active low) sets 65536 bytes, unit 16 and one free
// segment covering the memory; no clearing pass is needed.
module best_fit_segment_allocator #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bfsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfsa_pkg::LEN_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [bfsa_pkg::OWN_W-1:0]        in_owner_id,
  input  logic [bfsa_pkg::LEN_W-1:0]        in_request_bytes,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [bfsa_pkg::START_W-1:0]      out_seg_start,
  output logic [bfsa_pkg::LEN_W-1:0]        out_seg_length,
  output logic signed [bfsa_pkg::FILL_W-1:0] out_fill_owner
);

  localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);

  logic [bfsa_pkg::LEN_W-1:0]  total_r, total_nxt;
  logic [bfsa_pkg::UNIT_W-1:0] unit_r, unit_nxt;
  logic [bfsa_pkg::UNIT_W-1:0] unit_eff;
  logic                        clear;

  bfsa_pkg::rem_req_t          rem_req;
  bfsa_pkg::rem_rsp_t          rem_rsp;
  bfsa_pkg::result_t           res;
  bfsa_pkg::seg_entry_t        rd_data;
  bfsa_pkg::seg_entry_t        wr_data;
  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            wr_addr;
  logic                        wr_en;

  assign clear = cfg_we && (cfg_index == bfsa_pkg::REG_TOTAL);

  always_comb begin
    total_nxt = total_r;
    unit_nxt  = unit_r;
    if (clear) begin
      total_nxt = (cfg_data > bfsa_pkg::MEM_LIMIT) ? bfsa_pkg::MEM_LIMIT : cfg_data;
    end else if (cfg_we && (cfg_index == bfsa_pkg::REG_UNIT)) begin
      unit_nxt = cfg_data[bfsa_pkg::UNIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= bfsa_pkg::MEM_LIMIT;
      unit_r  <= bfsa_pkg::UNIT_RESET;
    end else begin
      total_r <= total_nxt;
      unit_r  <= unit_nxt;
    end
  end

  // a zero unit behaves as one byte
  assign unit_eff = (unit_r == '0) ? bfsa_pkg::UNIT_MIN : unit_r;

  bfsa_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  bfsa_table #(
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (clear),
    .total   (total_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bfsa_seq #(
    .DEPTH (MAX_SEGMENTS)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .clear            (clear),
    .unit             (unit_eff),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_owner_id      (in_owner_id),
    .in_request_bytes (in_request_bytes),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_res          (res),
    .rem_req          (rem_req),
    .rem_rsp          (rem_rsp),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data)
  );

  assign out_status     = res.status;
  assign out_seg_start  = res.start;
  assign out_seg_length = res.len;
  assign out_fill_owner = res.fill;

endmodule
